FILE: hdl/selu_pkg.sv
// Shared types and constants for the scaled exponential / logarithm unit.
// No dependencies; used by selu_mul64 and scaled_exp_log_unit.
package selu_pkg;

    localparam int FRAC_BITS_DEF = 16;

    // Wide multiplier operand width and its split into halves
    localparam int MUL_W  = 64;
    localparam int HALF_W = MUL_W / 2;

    localparam logic [63:0] ONE62      = 64'h4000_0000_0000_0000;
    localparam logic [63:0] LOG2E_Q62  = 64'h5C55_1D94_AE0B_F85D;
    localparam logic [63:0] LN2_Q62    = 64'h2C5C_85FD_F473_DE6A;
    localparam logic [63:0] LOG10E_Q62 = 64'h1BCB_7B15_26E5_0E32;

    localparam logic [1:0] MODE_EXP   = 2'd0;
    localparam logic [1:0] MODE_LN    = 2'd1;
    localparam logic [1:0] MODE_LOG10 = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_SAT    = 2'd1;
    localparam logic [1:0] ST_DOMAIN = 2'd2;

    localparam logic REG_MODE  = 1'b0;
    localparam logic REG_SCALE = 1'b1;

endpackage

FILE: hdl/selu_mul64.sv
// Two-stage unsigned 64 x 64 multiplier with a full 128-bit product.
// Depends on selu_pkg for the operand widths.
module selu_mul64
(
    input  logic                           clk,
    input  logic [selu_pkg::MUL_W-1:0]     a,
    input  logic [selu_pkg::MUL_W-1:0]     b,
    output logic [2*selu_pkg::MUL_W-1:0]   prod
);

    localparam int W  = selu_pkg::MUL_W;
    localparam int HW = selu_pkg::HALF_W;

    logic [W-1:0]   pp00_reg;
    logic [W-1:0]   pp01_reg;
    logic [W-1:0]   pp10_reg;
    logic [W-1:0]   pp11_reg;
    logic [2*W-1:0] prod_reg;

    // first stage: four half-width partial products
    always_ff @(posedge clk)
    begin
        pp00_reg <= W'(a[HW-1:0]) * W'(b[HW-1:0]);
        pp01_reg <= W'(a[HW-1:0]) * W'(b[W-1:HW]);
        pp10_reg <= W'(a[W-1:HW]) * W'(b[HW-1:0]);
        pp11_reg <= W'(a[W-1:HW]) * W'(b[W-1:HW]);
    end

    // second stage: align and sum
    always_ff @(posedge clk)
    begin
        prod_reg <= {pp11_reg, pp00_reg}
                  + ((2*W)'(pp01_reg) << HW)
                  + ((2*W)'(pp10_reg) << HW);
    end

    assign prod = prod_reg;

endmodule

FILE: hdl/scaled_exp_log_unit.sv
// Top level of the scaled exponential / logarithm unit: full datapath pipeline.
// Depends on selu_pkg and selu_mul64.

// One signed fixed-point sample enters in every cycle (busy never rises) and its result
// leaves on strobe; results cannot be held off, so the receiver must take one per cycle.
// The latency is set by the series expansions: 24 exponential terms and 20 logarithm
// terms, each a 64-bit multiply followed by an exact divide (reciprocal multiply plus one
// correction) by n for exponential term n and by 2n+1 for logarithm term n, six stages
// per term, and by the 31-stage radix-4 divider that forms the log argument. mode and scale
// may only be written while no sample is in flight; cfg_ready is always high.
module scaled_exp_log_unit
#(
    parameter int FRAC_BITS = selu_pkg::FRAC_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] sample,
    input  logic               last,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [31:0]        cfg_data,
    output logic               strobe,
    output logic signed [31:0] value,
    output logic [1:0]         status,
    output logic               last_out
);

    localparam int EXP_TERMS  = 24;
    localparam int LOG_TERMS  = 20;
    localparam int DIV_STAGES = 31;
    localparam int EXP_LAT    = 8 + 6 * EXP_TERMS + 2;
    localparam int LOG_LAT    = 2 + DIV_STAGES + 3 + 6 * LOG_TERMS + 6;
    localparam int EXP_DLY    = LOG_LAT - EXP_LAT;
    localparam int OUT_STAGE  = LOG_LAT + 1;

    localparam logic signed [63:0] EXP_LIM   = 64'sd32 <<< (2 * FRAC_BITS);
    localparam int                 M_SHIFT   = 56 - 2 * FRAC_BITS;
    localparam logic signed [8:0]  EXP_SBASE = 9'(62 - FRAC_BITS);
    localparam int                 L10_SHIFT = 118 - FRAC_BITS;

    typedef struct packed {
        logic [63:0]       w;
        logic signed [7:0] k;
        logic              ovf;
        logic              unf;
    } exp_ctx_t;

    typedef struct packed {
        logic [63:0] s2;
        logic [63:0] t;
        logic        dneg;
        logic        dom;
    } log_ctx_t;

    typedef struct packed {
        logic [31:0] val;
        logic [1:0]  st;
    } res_t;

    function automatic logic [63:0] shr62(input logic [127:0] p);
        begin
            return (p[127:126] != 2'b00) ? '1 : p[125:62];
        end
    endfunction

    function automatic logic [63:0] round_shr(input logic [127:0] p, input int sh);
        logic [128:0] acc;
        begin
            acc = ({1'b0, p} + (129'd1 << (sh - 1))) >> sh;
            return (acc[128:64] != '0) ? '1 : acc[63:0];
        end
    endfunction

    // ------------------------------------------------------------------
    // configuration and control
    // ------------------------------------------------------------------
    logic [1:0]         mode_reg;
    logic signed [31:0] scale_reg;
    logic               vld_reg [0:OUT_STAGE];
    logic               lst_reg [0:OUT_STAGE];

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= selu_pkg::MODE_EXP;
            scale_reg <= 32'sd1 <<< FRAC_BITS;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                selu_pkg::REG_MODE:  mode_reg  <= cfg_data[1:0];
                selu_pkg::REG_SCALE: scale_reg <= cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= OUT_STAGE; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else
        begin
            vld_reg[0] <= start;
            for (int i = 1; i <= OUT_STAGE; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lst_reg[0] <= last;
        for (int i = 1; i <= OUT_STAGE; i++)
        begin
            lst_reg[i] <= lst_reg[i-1];
        end
    end

    logic signed [31:0] x0_reg;

    always_ff @(posedge clk)
    begin
        x0_reg <= sample;
    end

    // ------------------------------------------------------------------
    // exponential path: range reduction to 2^k * exp(w)
    // ------------------------------------------------------------------
    logic signed [63:0] ep1_reg;
    logic [63:0]        em2_reg;
    logic [2:0]         eflg2_reg, eflg3_reg, eflg4_reg;   // {neg, ovf, unf}
    logic [127:0]       el2e_prod;
    logic signed [7:0]  ek5_reg, ek6_reg, ek7_reg;
    logic [55:0]        ef5_reg;
    logic [1:0]         eflg5_reg, eflg6_reg, eflg7_reg;   // {ovf, unf}
    logic [127:0]       eln2_prod;
    logic [63:0]        emag;
    logic [63:0]        eu;
    logic [7:0]         ek_raw;
    logic [55:0]        ef;

    always_comb
    begin
        emag   = ep1_reg[63] ? 64'(-ep1_reg) : 64'(ep1_reg);
        eu     = shr62(el2e_prod);
        ek_raw = eu[63:56];
        ef     = eu[55:0];
    end

    always_ff @(posedge clk)
    begin
        ep1_reg   <= x0_reg * scale_reg;
        em2_reg   <= emag << M_SHIFT;
        eflg2_reg <= {ep1_reg[63], ep1_reg >= EXP_LIM, ep1_reg <= -EXP_LIM};
        eflg3_reg <= eflg2_reg;
        eflg4_reg <= eflg3_reg;
        if (eflg4_reg[2])
        begin
            // negative argument: step k down one and take the fraction complement
            ek5_reg <= -signed'(ek_raw) - 8'(ef != '0);
            ef5_reg <= -ef;
        end
        else
        begin
            ek5_reg <= signed'(ek_raw);
            ef5_reg <= ef;
        end
        eflg5_reg <= eflg4_reg[1:0];
        ek6_reg   <= ek5_reg;
        ek7_reg   <= ek6_reg;
        eflg6_reg <= eflg5_reg;
        eflg7_reg <= eflg6_reg;
    end

    selu_mul64 u_mul_l2e
    (
        .clk  (clk),
        .a    (em2_reg),
        .b    (selu_pkg::LOG2E_Q62),
        .prod (el2e_prod)
    );

    selu_mul64 u_mul_ln2
    (
        .clk  (clk),
        .a    ({2'b00, ef5_reg, 6'b000000}),
        .b    (selu_pkg::LN2_Q62),
        .prod (eln2_prod)
    );

    // Taylor series of exp(w): e accumulates, term carries w^n/n!
    logic [63:0] ex_e_reg    [0:EXP_TERMS];
    logic [63:0] ex_term_reg [0:EXP_TERMS];
    exp_ctx_t    ex_ctx_reg  [0:EXP_TERMS];

    always_ff @(posedge clk)
    begin
        ex_e_reg[0]       <= '0;
        ex_term_reg[0]    <= selu_pkg::ONE62;
        ex_ctx_reg[0].w   <= shr62(eln2_prod);
        ex_ctx_reg[0].k   <= ek7_reg;
        ex_ctx_reg[0].ovf <= eflg7_reg[1];
        ex_ctx_reg[0].unf <= eflg7_reg[0];
    end

    for (genvar gn = 1; gn <= EXP_TERMS; gn++)
    begin : g_exp
        localparam int           DIV_N   = gn;
        localparam int           DIV_L   = $clog2(DIV_N);
        localparam logic [127:0] RECIP_W = (128'd1 << (63 + DIV_L)) / DIV_N;
        localparam logic [63:0]  RECIP   = RECIP_W[63:0];

        logic [127:0] tprod;
        logic [127:0] rprod;
        logic [63:0]  e_pipe_reg [0:4];
        exp_ctx_t     c_pipe_reg [0:4];
        logic [63:0]  tsat_reg   [0:2];
        logic [63:0]  q_est;
        logic [63:0]  rem;
        logic [63:0]  quo;

        selu_mul64 u_mul_term
        (
            .clk  (clk),
            .a    (ex_term_reg[gn-1]),
            .b    (ex_ctx_reg[gn-1].w),
            .prod (tprod)
        );

        selu_mul64 u_mul_recip
        (
            .clk  (clk),
            .a    (tsat_reg[0]),
            .b    (RECIP),
            .prod (rprod)
        );

        // quotient estimate is low by at most one
        always_comb
        begin
            q_est = 64'(rprod >> (63 + DIV_L));
            rem   = tsat_reg[2] - 64'(q_est * 64'(DIV_N));
            quo   = q_est + 64'(rem >= 64'(DIV_N));
        end

        always_ff @(posedge clk)
        begin
            e_pipe_reg[0] <= ex_e_reg[gn-1] + ex_term_reg[gn-1];
            c_pipe_reg[0] <= ex_ctx_reg[gn-1];
            for (int i = 1; i <= 4; i++)
            begin
                e_pipe_reg[i] <= e_pipe_reg[i-1];
                c_pipe_reg[i] <= c_pipe_reg[i-1];
            end
            tsat_reg[0]     <= shr62(tprod);
            tsat_reg[1]     <= tsat_reg[0];
            tsat_reg[2]     <= tsat_reg[1];
            ex_term_reg[gn] <= quo;
            ex_e_reg[gn]    <= e_pipe_reg[4];
            ex_ctx_reg[gn]  <= c_pipe_reg[4];
        end
    end

    logic [63:0]       ef1_e_reg;
    exp_ctx_t          ef1_ctx_reg;
    res_t              exp_res;
    res_t              exp_dly_reg [0:EXP_DLY];
    logic signed [8:0] esh;
    logic [64:0]       er65;

    always_comb
    begin
        esh     = EXP_SBASE - {ef1_ctx_reg.k[7], ef1_ctx_reg.k};
        er65    = ({1'b0, ef1_e_reg} + (65'd1 << (esh[5:0] - 6'd1))) >> esh[5:0];
        exp_res = '{val: 32'h7FFF_FFFF, st: selu_pkg::ST_SAT};
        if (ef1_ctx_reg.ovf)
        begin
            exp_res = '{val: 32'h7FFF_FFFF, st: selu_pkg::ST_SAT};
        end
        else if (ef1_ctx_reg.unf)
        begin
            exp_res = '{val: 32'h0, st: selu_pkg::ST_OK};
        end
        else if (esh < 9'sd1)
        begin
            exp_res = '{val: 32'h7FFF_FFFF, st: selu_pkg::ST_SAT};
        end
        else if (esh > 9'sd63)
        begin
            exp_res = '{val: 32'h0, st: selu_pkg::ST_OK};
        end
        else if (er65 > 65'h7FFF_FFFF)
        begin
            exp_res = '{val: 32'h7FFF_FFFF, st: selu_pkg::ST_SAT};
        end
        else
        begin
            exp_res = '{val: er65[31:0], st: selu_pkg::ST_OK};
        end
    end

    always_ff @(posedge clk)
    begin
        ef1_e_reg      <= ex_e_reg[EXP_TERMS] + ex_term_reg[EXP_TERMS];
        ef1_ctx_reg    <= ex_ctx_reg[EXP_TERMS];
        exp_dly_reg[0] <= exp_res;
        for (int i = 1; i <= EXP_DLY; i++)
        begin
            exp_dly_reg[i] <= exp_dly_reg[i-1];
        end
    end

    // ------------------------------------------------------------------
    // log path: normalize, s = (m-1)/(m+1), atanh series
    // ------------------------------------------------------------------
    logic [4:0]        le1_reg;
    logic [30:0]       lx1_reg;
    logic              ldom1_reg;
    logic [4:0]        le;
    logic [30:0]       lmq;
    logic signed [6:0] ld;
    logic [4:0]        ldmag;
    logic [68:0]       ltp;

    always_comb
    begin
        le = '0;
        for (int i = 0; i <= 30; i++)
        begin
            if (x0_reg[i])
            begin
                le = 5'(i);
            end
        end
        lmq   = lx1_reg << (5'd30 - le1_reg);
        ld    = signed'({2'b00, le1_reg}) - 7'(FRAC_BITS);
        ldmag = ld[6] ? 5'(-ld) : ld[4:0];
        ltp   = 69'(selu_pkg::LN2_Q62) * 69'(ldmag);
    end

    logic [31:0] dv_r_reg   [0:DIV_STAGES];
    logic [61:0] dv_q_reg   [0:DIV_STAGES];
    logic [31:0] dv_den_reg [0:DIV_STAGES];
    log_ctx_t    dv_ctx_reg [0:DIV_STAGES];

    always_ff @(posedge clk)
    begin
        le1_reg   <= le;
        lx1_reg   <= x0_reg[30:0];
        ldom1_reg <= (x0_reg <= 32'sd0);
        dv_r_reg[0]        <= {1'b0, lmq - 31'h4000_0000};
        dv_den_reg[0]      <= {1'b0, lmq} + 32'h4000_0000;
        dv_q_reg[0]        <= '0;
        dv_ctx_reg[0].s2   <= '0;
        dv_ctx_reg[0].t    <= {1'b0, ltp[68:6]};
        dv_ctx_reg[0].dneg <= ld[6];
        dv_ctx_reg[0].dom  <= ldom1_reg;
    end

    // restoring divider, two quotient bits per stage
    for (genvar gd = 1; gd <= DIV_STAGES; gd++)
    begin : g_div
        logic [32:0] r_a;
        logic [32:0] r_b;
        logic [31:0] r_mid;
        logic        b_hi;
        logic        b_lo;

        always_comb
        begin
            r_a   = {dv_r_reg[gd-1], 1'b0};
            b_hi  = r_a >= {1'b0, dv_den_reg[gd-1]};
            r_mid = b_hi ? 32'(r_a - {1'b0, dv_den_reg[gd-1]}) : r_a[31:0];
            r_b   = {r_mid, 1'b0};
            b_lo  = r_b >= {1'b0, dv_den_reg[gd-1]};
        end

        always_ff @(posedge clk)
        begin
            dv_r_reg[gd]   <= b_lo ? 32'(r_b - {1'b0, dv_den_reg[gd-1]}) : r_b[31:0];
            dv_q_reg[gd]   <= {dv_q_reg[gd-1][59:0], b_hi, b_lo};
            dv_den_reg[gd] <= dv_den_reg[gd-1];
            dv_ctx_reg[gd] <= dv_ctx_reg[gd-1];
        end
    end

    logic [127:0] lsq_prod;
    logic [63:0]  ls_reg [0:1];
    log_ctx_t     lc_reg [0:1];

    selu_mul64 u_mul_sq
    (
        .clk  (clk),
        .a    ({2'b00, dv_q_reg[DIV_STAGES]}),
        .b    ({2'b00, dv_q_reg[DIV_STAGES]}),
        .prod (lsq_prod)
    );

    logic [63:0] lg_sum_reg  [0:LOG_TERMS];
    logic [63:0] lg_term_reg [0:LOG_TERMS];
    logic [63:0] lg_q_reg    [0:LOG_TERMS];
    log_ctx_t    lg_ctx_reg  [0:LOG_TERMS];

    always_ff @(posedge clk)
    begin
        ls_reg[0] <= {2'b00, dv_q_reg[DIV_STAGES]};
        ls_reg[1] <= ls_reg[0];
        lc_reg[0] <= dv_ctx_reg[DIV_STAGES];
        lc_reg[1] <= lc_reg[0];
        lg_sum_reg[0]     <= ls_reg[1];
        lg_term_reg[0]    <= ls_reg[1];
        lg_q_reg[0]       <= '0;
        lg_ctx_reg[0].s2  <= shr62(lsq_prod);
        lg_ctx_reg[0].t   <= lc_reg[1].t;
        lg_ctx_reg[0].dneg <= lc_reg[1].dneg;
        lg_ctx_reg[0].dom <= lc_reg[1].dom;
    end

    for (genvar gj = 1; gj <= LOG_TERMS; gj++)
    begin : g_log
        localparam int           DIV_N   = 2 * gj + 1;
        localparam int           DIV_L   = $clog2(DIV_N);
        localparam logic [127:0] RECIP_W = (128'd1 << (63 + DIV_L)) / DIV_N;
        localparam logic [63:0]  RECIP   = RECIP_W[63:0];

        logic [127:0] tprod;
        logic [127:0] rprod;
        logic [63:0]  s_pipe_reg [0:4];
        log_ctx_t     c_pipe_reg [0:4];
        logic [63:0]  tsat_reg   [0:2];
        logic [63:0]  q_est;
        logic [63:0]  rem;
        logic [63:0]  quo;

        selu_mul64 u_mul_term
        (
            .clk  (clk),
            .a    (lg_term_reg[gj-1]),
            .b    (lg_ctx_reg[gj-1].s2),
            .prod (tprod)
        );

        selu_mul64 u_mul_recip
        (
            .clk  (clk),
            .a    (tsat_reg[0]),
            .b    (RECIP),
            .prod (rprod)
        );

        always_comb
        begin
            q_est = 64'(rprod >> (63 + DIV_L));
            rem   = tsat_reg[2] - 64'(q_est * 64'(DIV_N));
            quo   = q_est + 64'(rem >= 64'(DIV_N));
        end

        always_ff @(posedge clk)
        begin
            s_pipe_reg[0] <= lg_sum_reg[gj-1] + lg_q_reg[gj-1];
            c_pipe_reg[0] <= lg_ctx_reg[gj-1];
            for (int i = 1; i <= 4; i++)
            begin
                s_pipe_reg[i] <= s_pipe_reg[i-1];
                c_pipe_reg[i] <= c_pipe_reg[i-1];
            end
            tsat_reg[0]     <= shr62(tprod);
            tsat_reg[1]     <= tsat_reg[0];
            tsat_reg[2]     <= tsat_reg[1];
            lg_term_reg[gj] <= tsat_reg[2];
            lg_q_reg[gj]    <= quo;
            lg_sum_reg[gj]  <= s_pipe_reg[4];
            lg_ctx_reg[gj]  <= c_pipe_reg[4];
        end
    end

    logic [63:0]        lf1_sum_reg;
    log_ctx_t           lf1_ctx_reg;
    logic signed [63:0] lf2_l_reg;
    logic               lf2_dom_reg;
    logic [63:0]        lf3_a_reg, lf3_b_reg;
    logic               lf3_neg_reg, lf3_dom_reg;
    logic               lf4_neg_reg, lf4_dom_reg;
    logic               lf5_neg_reg, lf5_dom_reg;
    logic [127:0]       lf_prod;
    logic [63:0]        lres;
    logic [63:0]        lmag;
    logic [31:0]        scmag;
    logic [63:0]        lr;
    res_t               log_res;
    res_t               lg_res_reg;
    logic               lg_dom_reg;

    always_comb
    begin
        lres  = {6'b000000, lf1_sum_reg[62:5]};
        lmag  = lf2_l_reg[63] ? 64'(-lf2_l_reg) : 64'(lf2_l_reg);
        scmag = scale_reg[31] ? 32'(-scale_reg) : 32'(scale_reg);
        lr    = (mode_reg == selu_pkg::MODE_LN) ? round_shr(lf_prod, 56)
                                                : round_shr(lf_prod, L10_SHIFT);
        if (lf5_neg_reg)
        begin
            if (lr > 64'h8000_0000)
            begin
                log_res = '{val: 32'h8000_0000, st: selu_pkg::ST_SAT};
            end
            else
            begin
                log_res = '{val: 32'(64'd0 - lr), st: selu_pkg::ST_OK};
            end
        end
        else if (lr > 64'h7FFF_FFFF)
        begin
            log_res = '{val: 32'h7FFF_FFFF, st: selu_pkg::ST_SAT};
        end
        else
        begin
            log_res = '{val: lr[31:0], st: selu_pkg::ST_OK};
        end
    end

    always_ff @(posedge clk)
    begin
        lf1_sum_reg <= lg_sum_reg[LOG_TERMS] + lg_q_reg[LOG_TERMS];
        lf1_ctx_reg <= lg_ctx_reg[LOG_TERMS];
        lf2_l_reg   <= lf1_ctx_reg.dneg ? signed'(lres - lf1_ctx_reg.t)
                                        : signed'(lres + lf1_ctx_reg.t);
        lf2_dom_reg <= lf1_ctx_reg.dom;
        if (mode_reg == selu_pkg::MODE_LN)
        begin
            lf3_a_reg   <= {32'h0, scmag};
            lf3_b_reg   <= lmag;
            lf3_neg_reg <= scale_reg[31] ^ lf2_l_reg[63];
        end
        else
        begin
            lf3_a_reg   <= lmag;
            lf3_b_reg   <= selu_pkg::LOG10E_Q62;
            lf3_neg_reg <= lf2_l_reg[63];
        end
        lf3_dom_reg <= lf2_dom_reg;
        lf4_neg_reg <= lf3_neg_reg;
        lf4_dom_reg <= lf3_dom_reg;
        lf5_neg_reg <= lf4_neg_reg;
        lf5_dom_reg <= lf4_dom_reg;
        lg_res_reg  <= log_res;
        lg_dom_reg  <= lf5_dom_reg;
    end

    selu_mul64 u_mul_fin
    (
        .clk  (clk),
        .a    (lf3_a_reg),
        .b    (lf3_b_reg),
        .prod (lf_prod)
    );

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    logic signed [31:0] value_reg;
    logic [1:0]         status_reg;

    always_ff @(posedge clk)
    begin
        if (mode_reg == selu_pkg::MODE_EXP)
        begin
            value_reg  <= exp_dly_reg[EXP_DLY].val;
            status_reg <= exp_dly_reg[EXP_DLY].st;
        end
        else if (lg_dom_reg)
        begin
            value_reg  <= 32'sh8000_0000;
            status_reg <= selu_pkg::ST_DOMAIN;
        end
        else
        begin
            value_reg  <= lg_res_reg.val;
            status_reg <= lg_res_reg.st;
        end
    end

    assign strobe   = vld_reg[OUT_STAGE];
    assign last_out = lst_reg[OUT_STAGE];
    assign value    = value_reg;
    assign status   = status_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##(OUT_STAGE + 1) strobe)
        else $error("transfer did not come out after the pipeline latency");

    a_domain_value: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && status == selu_pkg::ST_DOMAIN |-> value == 32'sh8000_0000)
        else $error("domain status without the most negative value");

    a_exp_no_domain: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && mode_reg == selu_pkg::MODE_EXP |-> status != selu_pkg::ST_DOMAIN)
        else $error("domain status in exponential mode");

    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && status == selu_pkg::ST_SAT |->
            value == 32'sh7FFF_FFFF || value == 32'sh8000_0000)
        else $error("saturation status without a full-scale value");

endmodule
